// ----- hdl/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the level crossing controller.
// ----------------------------------------------------------------------------
package lcc_pkg;

  typedef enum logic [2:0] {
    MODE_OPEN     = 3'd0,
    MODE_WARNING  = 3'd1,
    MODE_LOWERING = 3'd2,
    MODE_CLOSED   = 3'd3,
    MODE_RAISING  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_APPROACH = 2'd1,
    OP_ENTER    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DSTART,
    B_DWAIT,
    B_EXEC
  } bstate_t;

  localparam logic [1:0] CFG_PREWARN = 2'd0;
  localparam logic [1:0] CFG_TRAVEL  = 2'd1;
  localparam logic [1:0] CFG_BLINK   = 2'd2;

  localparam logic [15:0] PREWARN_RST = 16'd3000;
  localparam logic [14:0] TRAVEL_RST  = 15'd8000;
  localparam logic [9:0]  BLINK_RST   = 10'd500;

  localparam logic [14:0] TRAVEL_MIN = 15'd1000;
  localparam logic [9:0]  HALF_MIN   = 10'd1;
  localparam logic [9:0]  HALF_MAX   = 10'd1000;

  localparam logic [16:0] ANGLE_UP       = 17'd90000;
  localparam logic [16:0] ANGLE_LOW_SNAP = 17'd1000;
  localparam logic [16:0] ANGLE_UP_SNAP  = 17'd89000;
  localparam logic [16:0] PHASE_MAX      = 17'd131071;

  localparam int DIV_W     = 28;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  delta_ms;
    logic [15:0] train_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  crossing_state;
    logic [16:0] barrier_angle_mdeg;
    logic        lamp_a_on;
    logic        lamp_b_on;
    logic        road_blocked;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  delta_ms;
    logic [15:0] train_id;
  } cmd_t;

  typedef struct packed {
    logic [15:0] prewarn_ms;
    logic [14:0] barrier_travel_ms;
    logic [9:0]  blink_half_period_ms;
  } cfg_t;

endpackage

// ----- hdl/lcc_front.sv -----
// ----------------------------------------------------------------------------
// lcc_front
// Accepts input items, decodes the kind into a command and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
module lcc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  lcc_pkg::in_item_t item,
  output logic              cmd_valid,
  output lcc_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  lcc_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  lcc_pkg::cmd_t cmd_in;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    unique case (item.kind)
      lcc_pkg::OP_TICK:     cmd_in.op = lcc_pkg::OP_TICK;
      lcc_pkg::OP_APPROACH: cmd_in.op = lcc_pkg::OP_APPROACH;
      lcc_pkg::OP_ENTER:    cmd_in.op = lcc_pkg::OP_ENTER;
      default:              cmd_in.op = lcc_pkg::OP_CLEAR;
    endcase
    cmd_in.delta_ms = item.delta_ms;
    cmd_in.train_id = item.train_id;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cmd_in;
  end

endmodule

// ----- hdl/lcc_div.sv -----
// ----------------------------------------------------------------------------
// lcc_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module lcc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lcc_pkg::DIV_W-1:0]  dividend,
  input  logic [14:0]                divisor,
  output logic                       done,
  output logic [lcc_pkg::DIV_W-1:0]  quotient
);

  logic [14:0]               rem;
  logic [lcc_pkg::DIV_W-1:0] quo;
  logic [lcc_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic [15:0]               r1;
  logic [15:0]               r2;
  logic [14:0]               r1s;
  logic [14:0]               r2s;
  logic                      b1;
  logic                      b2;

  always_comb begin
    r1  = {rem, quo[lcc_pkg::DIV_W-1]};
    b1  = (r1 >= {1'b0, divisor});
    r1s = b1 ? 15'(r1 - {1'b0, divisor}) : r1[14:0];
    r2  = {r1s, quo[lcc_pkg::DIV_W-2]};
    b2  = (r2 >= {1'b0, divisor});
    r2s = b2 ? 15'(r2 - {1'b0, divisor}) : r2[14:0];
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lcc_pkg::CNT_W'(lcc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= r2s;
      quo <= {quo[lcc_pkg::DIV_W-3:0], b1, b2};
    end
  end

endmodule

// ----- hdl/lcc_back.sv -----
// ----------------------------------------------------------------------------
// lcc_back
// Carries out commands: crossing state machine, barrier motion, lamp blink,
// and a two-entry result queue.
// ----------------------------------------------------------------------------
module lcc_back (
  input  logic               clk,
  input  logic               rst,
  input  lcc_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  input  lcc_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               empty,
  input  logic               pop,
  output lcc_pkg::out_item_t result
);

  lcc_pkg::bstate_t state;
  lcc_pkg::bstate_t state_next;
  lcc_pkg::cmd_t    cur;
  logic             div_start;
  logic             div_done;
  logic             exec;
  logic [lcc_pkg::DIV_W-1:0] prod;
  logic [lcc_pkg::DIV_W-1:0] quo;
  logic [14:0]      travel;

  lcc_pkg::mode_t   mode;
  logic [16:0]      phase_elapsed;
  logic [16:0]      angle_now;
  logic             target_down;
  logic [10:0]      blink_elapsed;
  logic             blink_phase;
  logic             blocker_on;
  logic [15:0]      active_train;
  logic             active_valid;

  lcc_pkg::mode_t   mode_next;
  logic [16:0]      phase_next;
  logic [16:0]      angle_next;
  logic             target_next;
  logic [10:0]      blink_elapsed_next;
  logic             blink_phase_next;
  logic             blocker_next;
  logic [15:0]      active_train_next;
  logic             active_valid_next;

  lcc_pkg::out_item_t res_q [2];
  logic               res_wr;
  logic               res_rd;
  logic [1:0]         res_count;
  lcc_pkg::out_item_t res_in;

  assign travel = (cfg.barrier_travel_ms < lcc_pkg::TRAVEL_MIN) ?
                  lcc_pkg::TRAVEL_MIN : cfg.barrier_travel_ms;

  lcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (travel),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    div_start  = 1'b0;
    exec       = 1'b0;
    unique case (state)
      lcc_pkg::B_IDLE: begin
        if (cmd_valid && res_count != 2'd2) begin
          cmd_take   = 1'b1;
          state_next = (cmd.op == lcc_pkg::OP_TICK) ? lcc_pkg::B_MUL : lcc_pkg::B_EXEC;
        end
      end
      lcc_pkg::B_MUL:    state_next = lcc_pkg::B_DSTART;
      lcc_pkg::B_DSTART: begin
        div_start  = 1'b1;
        state_next = lcc_pkg::B_DWAIT;
      end
      lcc_pkg::B_DWAIT:  if (div_done) state_next = lcc_pkg::B_EXEC;
      lcc_pkg::B_EXEC: begin
        exec       = 1'b1;
        state_next = lcc_pkg::B_IDLE;
      end
      default:           state_next = lcc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lcc_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
    if (state == lcc_pkg::B_MUL) begin
      prod <= lcc_pkg::DIV_W'(cur.delta_ms) * lcc_pkg::DIV_W'(lcc_pkg::ANGLE_UP);
    end
  end

  always_comb begin
    logic [17:0] ph_sum;
    logic [16:0] step;
    logic [16:0] goal;
    logic [16:0] span;
    logic [10:0] be_sum;
    logic [9:0]  half;

    mode_next          = mode;
    phase_next         = phase_elapsed;
    angle_next         = angle_now;
    target_next        = target_down;
    blink_elapsed_next = blink_elapsed;
    blink_phase_next   = blink_phase;
    blocker_next       = blocker_on;
    active_train_next  = active_train;
    active_valid_next  = active_valid;

    ph_sum = {1'b0, phase_elapsed} + {8'd0, cur.delta_ms};
    step   = quo[16:0];
    half   = (cfg.blink_half_period_ms < lcc_pkg::HALF_MIN) ? lcc_pkg::HALF_MIN :
             (cfg.blink_half_period_ms > lcc_pkg::HALF_MAX) ? lcc_pkg::HALF_MAX :
             cfg.blink_half_period_ms;
    goal   = '0;
    span   = '0;
    be_sum = '0;

    unique case (cur.op)
      lcc_pkg::OP_TICK: begin
        unique case (mode)
          lcc_pkg::MODE_OPEN: begin
            target_next  = 1'b0;
            blocker_next = 1'b0;
          end
          lcc_pkg::MODE_WARNING: begin
            blocker_next = 1'b1;
            phase_next   = ph_sum[17] ? lcc_pkg::PHASE_MAX : ph_sum[16:0];
            if (phase_next >= {1'b0, cfg.prewarn_ms}) begin
              mode_next   = lcc_pkg::MODE_LOWERING;
              target_next = 1'b1;
            end
          end
          lcc_pkg::MODE_LOWERING: begin
            target_next = 1'b1;
            if (angle_now <= lcc_pkg::ANGLE_LOW_SNAP) begin
              angle_next   = '0;
              mode_next    = lcc_pkg::MODE_CLOSED;
              blocker_next = 1'b1;
            end
          end
          lcc_pkg::MODE_CLOSED: begin
            target_next  = 1'b1;
            blocker_next = 1'b1;
          end
          default: begin
            target_next = 1'b0;
            if (angle_now >= lcc_pkg::ANGLE_UP_SNAP) begin
              angle_next = lcc_pkg::ANGLE_UP;
              mode_next  = lcc_pkg::MODE_OPEN;
            end
          end
        endcase

        goal = target_next ? 17'd0 : lcc_pkg::ANGLE_UP;
        if (angle_next > goal) begin
          span       = angle_next - goal;
          angle_next = angle_next - ((step < span) ? step : span);
        end else if (angle_next < goal) begin
          span       = goal - angle_next;
          angle_next = angle_next + ((step < span) ? step : span);
        end

        if (mode_next != lcc_pkg::MODE_OPEN) begin
          be_sum = blink_elapsed + {1'b0, cur.delta_ms};
          if (be_sum >= {1'b0, half}) begin
            blink_elapsed_next = '0;
            blink_phase_next   = !blink_phase;
          end else begin
            blink_elapsed_next = be_sum;
          end
        end
      end
      lcc_pkg::OP_APPROACH: begin
        active_train_next = cur.train_id;
        active_valid_next = 1'b1;
        if (mode == lcc_pkg::MODE_OPEN) begin
          phase_next = '0;
          mode_next  = lcc_pkg::MODE_WARNING;
        end
      end
      lcc_pkg::OP_ENTER: begin
        active_train_next = cur.train_id;
        active_valid_next = 1'b1;
        mode_next         = lcc_pkg::MODE_CLOSED;
        angle_next        = '0;
        target_next       = 1'b1;
        blocker_next      = 1'b1;
      end
      lcc_pkg::OP_CLEAR: begin
        if (!active_valid || active_train == cur.train_id) begin
          active_valid_next = 1'b0;
          mode_next         = lcc_pkg::MODE_RAISING;
          target_next       = 1'b0;
        end
      end
      default: ;
    endcase

    res_in.crossing_state     = mode_next;
    res_in.barrier_angle_mdeg = angle_next;
    res_in.lamp_a_on          = (mode_next != lcc_pkg::MODE_OPEN) && blink_phase_next;
    res_in.lamp_b_on          = (mode_next != lcc_pkg::MODE_OPEN) && !blink_phase_next;
    res_in.road_blocked       = blocker_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= lcc_pkg::MODE_OPEN;
      phase_elapsed <= '0;
      angle_now     <= lcc_pkg::ANGLE_UP;
      target_down   <= 1'b0;
      blink_elapsed <= '0;
      blink_phase   <= 1'b0;
      blocker_on    <= 1'b0;
      active_train  <= '0;
      active_valid  <= 1'b0;
    end else if (exec) begin
      mode          <= mode_next;
      phase_elapsed <= phase_next;
      angle_now     <= angle_next;
      target_down   <= target_next;
      blink_elapsed <= blink_elapsed_next;
      blink_phase   <= blink_phase_next;
      blocker_on    <= blocker_next;
      active_train  <= active_train_next;
      active_valid  <= active_valid_next;
    end
  end

  // result queue
  assign empty  = (res_count == 2'd0);
  assign result = res_q[res_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (exec)          res_wr <= !res_wr;
      if (pop && !empty) res_rd <= !res_rd;
      res_count <= res_count + {1'b0, exec} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (exec) res_q[res_wr] <= res_in;
  end

endmodule

// ----- hdl/level_crossing_controller.sv -----
// ----------------------------------------------------------------------------
// level_crossing_controller
// Level crossing controller: crossing state, barrier angle, lamps, blocker.
// ----------------------------------------------------------------------------
// Input items (tick or train event) enter on item; a transfer happens when
// push is high and full is low. Each item yields one result on result, valid
// while empty is low and taken when pop is high.
// Registers are set through cfg_write/cfg_index/cfg_data, one per cycle, by
// the user only while the block is idle; the block does not enforce it.
// A front end decodes items into a two-deep command queue; the back end runs
// them one at a time. An event goes from the command queue through the EXEC
// state into the result queue; a tick also passes the MUL state, which
// multiplies delta_ms by the full angle, and the radix-4 divider that computes
// the barrier step. The back end takes no new command until the last is done.
// Results sit in a two-entry queue; when it is full the back end waits and
// the input queue fills, then full rises. Synchronous reset empties both
// queues, sets registers to their defaults and the barrier upright.
// ----------------------------------------------------------------------------
module level_crossing_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  lcc_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output lcc_pkg::out_item_t result,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  lcc_pkg::cfg_t cfg;
  logic          cmd_valid;
  lcc_pkg::cmd_t cmd;
  logic          cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prewarn_ms           <= lcc_pkg::PREWARN_RST;
      cfg.barrier_travel_ms    <= lcc_pkg::TRAVEL_RST;
      cfg.blink_half_period_ms <= lcc_pkg::BLINK_RST;
    end else if (cfg_write) begin
      if (cfg_index == lcc_pkg::CFG_PREWARN) cfg.prewarn_ms <= cfg_data;
      if (cfg_index == lcc_pkg::CFG_TRAVEL)  cfg.barrier_travel_ms <= cfg_data[14:0];
      if (cfg_index == lcc_pkg::CFG_BLINK)   cfg.blink_half_period_ms <= cfg_data[9:0];
    end
  end

  lcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  lcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- hdl/lcc_checker.sv -----
// ----------------------------------------------------------------------------
// lcc_port_checker
// Port-level assertions for the level crossing controller.
// ----------------------------------------------------------------------------
module lcc_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input lcc_pkg::in_item_t  item,
  input logic               empty,
  input logic               pop,
  input lcc_pkg::out_item_t result,
  input logic               cfg_write,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_closed_down: assert property (@(posedge clk) disable iff (rst)
    !empty && result.crossing_state == lcc_pkg::MODE_CLOSED |->
      result.barrier_angle_mdeg == 17'd0 && result.road_blocked)
    else $error("closed crossing with barrier up or road open");

  a_lamps: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.crossing_state == lcc_pkg::MODE_OPEN) ?
      (!result.lamp_a_on && !result.lamp_b_on) :
      (result.lamp_a_on != result.lamp_b_on)))
    else $error("lamp pattern does not match crossing state");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

endmodule

bind level_crossing_controller lcc_port_checker u_lcc_port_checker (.*);

// ----- bench/lcc_checker.sv -----
// ----------------------------------------------------------------------------
// lcc_checker
// Watches the item, result and register ports of the level crossing
// controller. Keeps its own copy of the crossing state and the registers,
// works out the result of every accepted item and compares each accepted
// result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lcc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  lcc_pkg::in_item_t  item,
  input  logic               empty,
  input  logic               pop,
  input  lcc_pkg::out_item_t result,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 waiting
);

  import lcc_pkg::*;

  logic [15:0] prewarn;
  logic [14:0] travel;
  logic [9:0]  half_period;

  mode_t       cur_mode;
  logic [16:0] phase_ms;
  logic [16:0] angle_mdeg;
  logic        go_down;
  logic [10:0] blink_ms;
  logic        lamp_phase;
  logic        blocker;
  logic [15:0] held_train;
  logic        train_held;

  out_item_t   pending_results[$];

  task automatic report_mismatch(input string msg);
    $display("lcc_checker: %s", msg);
    mismatches++;
  endtask

  function automatic void reset_crossing();
    prewarn     = PREWARN_RST;
    travel      = TRAVEL_RST;
    half_period = BLINK_RST;
    cur_mode    = MODE_OPEN;
    phase_ms    = '0;
    angle_mdeg  = ANGLE_UP;
    go_down     = 1'b0;
    blink_ms    = '0;
    lamp_phase  = 1'b0;
    blocker     = 1'b0;
    held_train  = '0;
    train_held  = 1'b0;
  endfunction

  function automatic void set_mode(input mode_t m);
    cur_mode = m;
    if (m == MODE_LOWERING || m == MODE_CLOSED) begin
      go_down = 1'b1;
      blocker = 1'b1;
    end else if (m == MODE_RAISING || m == MODE_OPEN) begin
      go_down = 1'b0;
    end
  endfunction

  function automatic out_item_t crossing_step(input in_item_t it);
    out_item_t   r;
    int unsigned dl;
    int unsigned acc;
    int unsigned travel_eff;
    int unsigned half_eff;
    int unsigned step;
    int unsigned goal;
    int unsigned gap;
    dl = it.delta_ms;
    case (it.kind)
      OP_TICK: begin
        case (cur_mode)
          MODE_OPEN: begin
            go_down = 1'b0;
            blocker = 1'b0;
          end
          MODE_WARNING: begin
            blocker = 1'b1;
            acc = phase_ms + dl;
            phase_ms = (acc > PHASE_MAX) ? PHASE_MAX : 17'(acc);
            if (phase_ms >= prewarn) set_mode(MODE_LOWERING);
          end
          MODE_LOWERING: begin
            go_down = 1'b1;
            if (angle_mdeg <= ANGLE_LOW_SNAP) begin
              angle_mdeg = '0;
              set_mode(MODE_CLOSED);
            end
          end
          MODE_CLOSED: begin
            go_down = 1'b1;
            blocker = 1'b1;
          end
          default: begin
            go_down = 1'b0;
            if (angle_mdeg >= ANGLE_UP_SNAP) begin
              angle_mdeg = ANGLE_UP;
              set_mode(MODE_OPEN);
            end
          end
        endcase
        // barrier moves after the state update, never past its goal
        travel_eff = (travel < TRAVEL_MIN) ? TRAVEL_MIN : travel;
        step = (dl * 32'(ANGLE_UP)) / travel_eff;
        goal = go_down ? 0 : 32'(ANGLE_UP);
        if (angle_mdeg > goal) begin
          gap = angle_mdeg - goal;
          angle_mdeg = 17'(angle_mdeg - ((step < gap) ? step : gap));
        end else if (angle_mdeg < goal) begin
          gap = goal - angle_mdeg;
          angle_mdeg = 17'(angle_mdeg + ((step < gap) ? step : gap));
        end
        if (cur_mode != MODE_OPEN) begin
          half_eff = half_period;
          if (half_eff < HALF_MIN) half_eff = HALF_MIN;
          if (half_eff > HALF_MAX) half_eff = HALF_MAX;
          acc = blink_ms + dl;
          if (acc >= half_eff) begin
            blink_ms   = '0;
            lamp_phase = ~lamp_phase;
          end else begin
            blink_ms = 11'(acc);
          end
        end
      end
      OP_APPROACH: begin
        held_train = it.train_id;
        train_held = 1'b1;
        if (cur_mode == MODE_OPEN) begin
          phase_ms = '0;
          set_mode(MODE_WARNING);
        end
      end
      OP_ENTER: begin
        held_train = it.train_id;
        train_held = 1'b1;
        set_mode(MODE_CLOSED);
        angle_mdeg = '0;
        go_down    = 1'b1;
      end
      default: begin
        if (!train_held || held_train == it.train_id) begin
          train_held = 1'b0;
          set_mode(MODE_RAISING);
        end
      end
    endcase
    r.crossing_state     = cur_mode;
    r.barrier_angle_mdeg = angle_mdeg;
    r.lamp_a_on          = (cur_mode != MODE_OPEN) && lamp_phase;
    r.lamp_b_on          = (cur_mode != MODE_OPEN) && !lamp_phase;
    r.road_blocked       = blocker;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      reset_crossing();
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_PREWARN) prewarn = cfg_data;
        else if (cfg_index == CFG_TRAVEL) travel = cfg_data[14:0];
        else if (cfg_index == CFG_BLINK) half_period = cfg_data[9:0];
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (result.crossing_state !== want.crossing_state)
            report_mismatch($sformatf("crossing_state got %0d expected %0d",
                                      result.crossing_state, want.crossing_state));
          if (result.barrier_angle_mdeg !== want.barrier_angle_mdeg)
            report_mismatch($sformatf("barrier_angle_mdeg got %0d expected %0d",
                                      result.barrier_angle_mdeg,
                                      want.barrier_angle_mdeg));
          if (result.lamp_a_on !== want.lamp_a_on)
            report_mismatch($sformatf("lamp_a_on got %b expected %b",
                                      result.lamp_a_on, want.lamp_a_on));
          if (result.lamp_b_on !== want.lamp_b_on)
            report_mismatch($sformatf("lamp_b_on got %b expected %b",
                                      result.lamp_b_on, want.lamp_b_on));
          if (result.road_blocked !== want.road_blocked)
            report_mismatch($sformatf("road_blocked got %b expected %b",
                                      result.road_blocked, want.road_blocked));
        end
      end
      if (push && !full) pending_results.push_back(crossing_step(item));
    end
    waiting <= pending_results.size();
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the level crossing controller bench. Runs a short directed sequence
// and then train runs with random content under several register settings,
// with random gaps on both sides and two long result stalls that fill the
// block. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  import lcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIRECTED_N  = 25;
  localparam int PHASE_ITEMS = 265;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    item;
  logic        empty;
  logic        pop;
  out_item_t   result;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int waiting;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int items_sent = 0;
  int tick_max = 40;
  int cycles = 0;

  level_crossing_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // result side: random gaps, plus long stalls on request
  initial begin : receiver
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // returns at the edge of the transfer with push still high
  task automatic send_op(input op_t op, input logic [9:0] dl, input logic [15:0] id);
    in_item_t it;
    it.kind     = op;
    it.delta_ms = dl;
    it.train_id = id;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  function automatic logic [9:0] rand_delta();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 10'($urandom_range(3));
    if (r < 40) return 10'($urandom_range(1023, 900));
    return 10'($urandom_range(1023));
  endfunction

  task automatic tick_run(input int n);
    repeat (n) send_op(OP_TICK, rand_delta(), 16'($urandom));
  endtask

  task automatic train_run();
    logic [15:0] id;
    id = 16'($urandom);
    send_op(OP_APPROACH, 10'($urandom), id);
    tick_run($urandom_range(tick_max, 1));
    if ($urandom_range(3) == 0) send_op(OP_ENTER, 10'($urandom), id);
    if ($urandom_range(4) == 0)
      send_op(OP_CLEAR, 10'($urandom), id ^ 16'($urandom_range(65535, 1)));
    tick_run($urandom_range(10));
    send_op(OP_CLEAR, 10'($urandom), id);
    tick_run($urandom_range(30, 1));
  endtask

  task automatic load_settings(input logic [15:0] pw, input logic [15:0] tr,
                               input logic [15:0] bh);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PREWARN;
    cfg_data  <= pw;
    @(posedge clk);
    cfg_index <= CFG_TRAVEL;
    cfg_data  <= tr;
    @(posedge clk);
    cfg_index <= CFG_BLINK;
    cfg_data  <= bh;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin : stimulus
    int goal;
    rst       = 1'b1;
    push      = 1'b0;
    item      = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_PREWARN;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 22;
    recv_idle = 73;
    send_op(OP_TICK, 10'd0, 16'h0000);
    send_op(OP_TICK, 10'h3FF, 16'hFFFF);
    send_op(OP_CLEAR, 10'h3FF, 16'h0000);    // no train held: raises from open
    send_op(OP_TICK, 10'd1000, 16'h0000);
    send_op(OP_APPROACH, 10'd0, 16'hFFFF);
    send_op(OP_APPROACH, 10'd0, 16'h1234);   // warning timer keeps running
    repeat (3) send_op(OP_TICK, 10'd1000, 16'h0000);
    repeat (2) send_op(OP_TICK, 10'h3FF, 16'h0000);
    send_op(OP_CLEAR, 10'd0, 16'hFFFF);      // other train, ignored
    send_op(OP_ENTER, 10'd0, 16'hAAAA);
    send_op(OP_TICK, 10'd0, 16'h0000);
    send_op(OP_CLEAR, 10'd0, 16'hAAAA);
    repeat (3) send_op(OP_TICK, 10'h3FF, 16'h0000);
    send_op(OP_APPROACH, 10'd0, 16'h5555);   // not open: stays raising
    send_op(OP_ENTER, 10'd0, 16'h0000);
    send_op(OP_CLEAR, 10'd0, 16'h0001);
    send_op(OP_CLEAR, 10'd0, 16'h0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_settings(16'd0, 16'd1000, 16'd1);
        1: load_settings(16'd60000, 16'd30000, 16'd1000);
        2: load_settings(16'd1500, 16'h8000, 16'hFC00);
        3: load_settings(16'd2500, 16'd999, 16'd1023);
        4: load_settings(16'($urandom_range(8000)), 16'($urandom_range(30000, 1000)),
                         16'($urandom_range(1000, 1)));
        default: load_settings(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (p < 2) begin
        send_idle = 22;
        recv_idle = 73;
      end else if (p < 4) begin
        send_idle = 73;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      tick_max = (p == 1 || p == 5) ? 160 : 40;
      if (p == 0 || p == 4) hold_reqs++;
      goal = DIRECTED_N + (p + 1) * PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 80) begin
          train_run();
        end else begin
          repeat ($urandom_range(5, 1))
            send_op(op_t'($urandom_range(3)), 10'($urandom), 16'($urandom));
        end
      end
      drain();
    end

    if (mismatches == 0 && waiting == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
